// ----- rtl/tpm_pkg.sv -----
// Package for the thermal pseudocolor mapper: widths, register indexes,
// pipeline control type and the elaboration-time palette and gray tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpm_pkg;

   localparam int COLOR_LEVELS = 1024;
   localparam int GRAY_LEVELS  = 256;

   localparam int TEMP_W      = 16;
   localparam int SCALE_W     = 32;
   localparam int SCALE_SHIFT = 20;
   localparam int PROD_W      = TEMP_W + SCALE_W;
   localparam int HI_W        = PROD_W - SCALE_SHIFT;
   localparam int CHAN_W      = 8;
   localparam int CSR_IDX_W   = 2;

   localparam int MAX_LEVELS = (COLOR_LEVELS > GRAY_LEVELS) ? COLOR_LEVELS : GRAY_LEVELS;
   localparam int TONE_W     = $clog2(MAX_LEVELS);
   localparam int COLOR_W    = $clog2(COLOR_LEVELS);
   localparam int GRAY_W     = $clog2(GRAY_LEVELS);

   // palette split into banks of at most 256 entries, read in parallel
   localparam int BANK_DEPTH = (COLOR_LEVELS < 256) ? COLOR_LEVELS : 256;
   localparam int BANK_W     = $clog2(BANK_DEPTH);
   localparam int NUM_BANKS  = (COLOR_LEVELS + BANK_DEPTH - 1) / BANK_DEPTH;

   localparam int STAGES = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TEMP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE = 2'd2;

   localparam logic [TEMP_W-1:0]  MIN_TEMP_RST   = 16'd0;
   localparam logic [SCALE_W-1:0] TONE_SCALE_RST = 32'd65536;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef rgb_type [COLOR_LEVELS-1:0]        palette_type;
   typedef logic [GRAY_LEVELS-1:0][CHAN_W-1:0] gray_ramp_type;

   typedef struct packed {
      logic [STAGES-1:0] load;   // stage register takes new contents
      logic [STAGES-1:0] full;   // stage holds a live item
   } pipe_ctl_type;

   localparam longint PAL_M  = COLOR_LEVELS - 1;
   localparam longint PAL_M2 = 2 * PAL_M;
   localparam longint GRAY_TOP = GRAY_LEVELS - 1;

   function automatic logic [CHAN_W-1:0] sat255(input longint v);
      return (v > 255) ? 8'd255 : CHAN_W'(v);
   endfunction

   // black-blue-cyan-green-yellow-red-white ramp, u = 10*t against odd multiples of M
   function automatic rgb_type palette_entry(input longint t);
      longint  u;
      longint  rr;
      longint  gg;
      longint  bb;
      rgb_type e;
      u  = 10 * t;
      rr = 0;
      gg = 0;
      bb = 0;
      if (u < PAL_M) begin
         bb = (2550 * t) / PAL_M;
      end else if (u < 3 * PAL_M) begin
         gg = (255 * (u - PAL_M)) / PAL_M2;
         bb = 255;
      end else if (u < 5 * PAL_M) begin
         gg = 255;
         bb = (255 * (5 * PAL_M - u)) / PAL_M2;
      end else if (u < 7 * PAL_M) begin
         rr = (255 * (u - 5 * PAL_M)) / PAL_M2;
         gg = 255;
      end else if (u < 9 * PAL_M) begin
         rr = 255;
         gg = (255 * (9 * PAL_M - u)) / PAL_M2;
      end else begin
         rr = 255;
         gg = (255 * (u - 9 * PAL_M)) / PAL_M;
         bb = gg;
      end
      e.red   = sat255(rr);
      e.green = sat255(gg);
      e.blue  = sat255(bb);
      return e;
   endfunction

   function automatic palette_type build_palette();
      palette_type p;
      for (int i = 0; i < COLOR_LEVELS; i++) begin
         p[i] = palette_entry(longint'(i));
      end
      return p;
   endfunction

   function automatic gray_ramp_type build_gray_ramp();
      gray_ramp_type g;
      for (int i = 0; i < GRAY_LEVELS; i++) begin
         g[i] = sat255((255 * longint'(i)) / GRAY_TOP);
      end
      return g;
   endfunction

endpackage : tpm_pkg

`default_nettype wire

// ----- rtl/tpm_tone.sv -----
// Tone path of the mapper: offset subtract, Q12.20 scale multiply and clamp.
// Three pipeline stages; uses tpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpm_tone (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tpm_pkg::pipe_ctl_type      ctl,
   input  wire logic [tpm_pkg::TEMP_W-1:0]  req_temperature,
   input  wire logic [tpm_pkg::TEMP_W-1:0]  min_temp,
   input  wire logic [tpm_pkg::SCALE_W-1:0] tone_scale,
   input  wire logic                       color_mode,
   output      logic [tpm_pkg::TONE_W-1:0]  tone,
   output      logic                       tone_color
);
   import tpm_pkg::*;

   localparam logic [TONE_W-1:0] COLOR_TOP = TONE_W'(COLOR_LEVELS - 1);
   localparam logic [TONE_W-1:0] GRAY_MAX  = TONE_W'(GRAY_LEVELS - 1);

   logic [TEMP_W:0]   diff_wide;
   logic              diff_pos;
   logic [TEMP_W-1:0] diff_ff;
   logic              pos_ff;
   logic              mode0_ff;
   logic [PROD_W-1:0] prod;
   logic [HI_W-1:0]   prod_hi_in;
   logic [HI_W-1:0]   prod_hi_ff;
   logic              mode1_ff;
   logic [TONE_W-1:0] top_sel;
   logic [TONE_W-1:0] tone_in;
   logic [TONE_W-1:0] tone_ff;
   logic              mode2_ff;

   // stage 1: sample minus offset, 17-bit signed
   assign diff_wide = {req_temperature[TEMP_W-1], req_temperature}
                    - {min_temp[TEMP_W-1], min_temp};
   assign diff_pos  = !diff_wide[TEMP_W] && (|diff_wide[TEMP_W-1:0]);

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         diff_ff  <= diff_wide[TEMP_W-1:0];
         pos_ff   <= diff_pos;
         mode0_ff <= color_mode;
      end
   end

   // stage 2: 16x32 multiply, keep bits above the fraction
   assign prod       = PROD_W'(diff_ff) * PROD_W'(tone_scale);
   assign prod_hi_in = pos_ff ? prod[PROD_W-1:SCALE_SHIFT] : '0;

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         prod_hi_ff <= prod_hi_in;
         mode1_ff   <= mode0_ff;
      end
   end

   // stage 3: saturate to the top level of the mode
   assign top_sel = mode1_ff ? COLOR_TOP : GRAY_MAX;
   assign tone_in = (prod_hi_ff > HI_W'(top_sel)) ? top_sel : prod_hi_ff[TONE_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         tone_ff  <= tone_in;
         mode2_ff <= mode1_ff;
      end
   end

   assign tone       = tone_ff;
   assign tone_color = mode2_ff;

   a_tone_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.full[2] |-> (tone_ff <= (mode2_ff ? COLOR_TOP : GRAY_MAX)))
      else $error("tone beyond the top level of its mode");

endmodule : tpm_tone

`default_nettype wire

// ----- rtl/tpm_lut.sv -----
// Color lookup of the mapper: banked palette and gray ramp reads, then bank
// select into the result registers. Uses tpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpm_lut (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tpm_pkg::pipe_ctl_type     ctl,
   input  wire logic [tpm_pkg::TONE_W-1:0] tone,
   input  wire logic                      tone_color,
   output      logic [tpm_pkg::CHAN_W-1:0] rsp_red,
   output      logic [tpm_pkg::CHAN_W-1:0] rsp_green,
   output      logic [tpm_pkg::CHAN_W-1:0] rsp_blue
);
   import tpm_pkg::*;

   localparam palette_type   PALETTE   = build_palette();
   localparam gray_ramp_type GRAY_RAMP = build_gray_ramp();

   rgb_type           bank_in [NUM_BANKS];
   rgb_type           bank_ff [NUM_BANKS];
   logic [BANK_W-1:0] lo;
   logic [CHAN_W-1:0] gray_in;
   logic [CHAN_W-1:0] gray_ff;
   logic [TONE_W-1:0] tone3_ff;
   logic              mode3_ff;
   rgb_type           color_sel;
   rgb_type           pixel_in;
   logic [CHAN_W-1:0] red_ff;
   logic [CHAN_W-1:0] green_ff;
   logic [CHAN_W-1:0] blue_ff;
   logic              mode4_ff;

   assign lo = tone[BANK_W-1:0];

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [COLOR_W-1:0] idx;
      assign idx = COLOR_W'(b * BANK_DEPTH) + COLOR_W'(lo);
      // last bank may be partial when the level count is not a bank multiple
      assign bank_in[b] = ({1'b0, idx} < (COLOR_W + 1)'(COLOR_LEVELS)) ? PALETTE[idx] : '0;
   end

   assign gray_in = ({1'b0, tone} < (TONE_W + 1)'(GRAY_LEVELS)) ?
                    GRAY_RAMP[tone[GRAY_W-1:0]] : '0;

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         bank_ff  <= bank_in;
         gray_ff  <= gray_in;
         tone3_ff <= tone;
         mode3_ff <= tone_color;
      end
   end

   always_comb begin
      color_sel = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         if ((tone3_ff >> BANK_W) == TONE_W'(b)) begin
            color_sel = bank_ff[b];
         end
      end
   end

   always_comb begin
      if (mode3_ff) begin
         pixel_in = color_sel;
      end else begin
         pixel_in.red   = gray_ff;
         pixel_in.green = gray_ff;
         pixel_in.blue  = gray_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         red_ff   <= pixel_in.red;
         green_ff <= pixel_in.green;
         blue_ff  <= pixel_in.blue;
         mode4_ff <= mode3_ff;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      (ctl.full[4] && !mode4_ff) |-> (red_ff == green_ff && green_ff == blue_ff))
      else $error("gray item with unequal channels");

endmodule : tpm_lut

`default_nettype wire

// ----- rtl/thermal_pseudocolor_mapper.sv -----
// Top level of the thermal pseudocolor mapper: configuration registers,
// pipeline control and the tone and lookup units. Uses tpm_pkg, tpm_tone, tpm_lut.
//
// Maps one signed Q12.4 temperature sample per clock to an RGB pixel while
// req_stall is low. The pipeline is five stages deep: a sample is registered
// through each stage in turn before it is presented on the rsp_ side, and a
// new sample is accepted every cycle in which req_stall is low. The stages are
// offset subtract, the 16x32 scale multiply, clamp, the parallel read of the
// palette banks (256 entries each) and gray ramp, and the bank select into the
// result register. Stages fill bubbles under output stall, and req_stall rises
// only when all five are occupied and the result is stalled.
// Registers are written through csr_write/csr_index/csr_wdata and must only
// change while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

module thermal_pseudocolor_mapper (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [tpm_pkg::TEMP_W-1:0]    req_temperature,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [tpm_pkg::CHAN_W-1:0]    rsp_red,
   output      logic [tpm_pkg::CHAN_W-1:0]    rsp_green,
   output      logic [tpm_pkg::CHAN_W-1:0]    rsp_blue,
   input  wire logic                         csr_write,
   input  wire logic [tpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tpm_pkg::SCALE_W-1:0]   csr_wdata
);
   import tpm_pkg::*;

   logic [TEMP_W-1:0]  min_temp_ff;
   logic [SCALE_W-1:0] tone_scale_ff;
   logic               color_mode_ff;
   logic [STAGES-1:0]  vld_ff;
   logic [STAGES-1:0]  vld_in;
   logic [STAGES-1:0]  free;
   pipe_ctl_type       ctl;
   logic [TONE_W-1:0]  tone;
   logic               tone_color;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_temp_ff   <= MIN_TEMP_RST;
         tone_scale_ff <= TONE_SCALE_RST;
         color_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MIN_TEMP:   min_temp_ff   <= csr_wdata[TEMP_W-1:0];
            CSR_TONE_SCALE: tone_scale_ff <= csr_wdata;
            CSR_COLOR_MODE: color_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // a stage may load when it is empty or its item moves on this cycle
   always_comb begin
      free[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         free[k] = !vld_ff[k] || free[k+1];
      end
      vld_in[0] = free[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         if (free[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl.load  = free;
   assign ctl.full  = vld_ff;
   assign req_stall = !free[0];
   assign rsp_valid = vld_ff[STAGES-1];

   tpm_tone u_tone (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_temperature (req_temperature),
      .min_temp        (min_temp_ff),
      .tone_scale      (tone_scale_ff),
      .color_mode      (color_mode_ff),
      .tone            (tone),
      .tone_color      (tone_color)
   );

   tpm_lut u_lut (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .tone       (tone),
      .tone_color (tone_color),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue)
   );

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&vld_ff) && rsp_stall))
      else $error("input stalled with room in the pipeline");

   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_item_not_dropped: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-1] && rsp_stall) |=> vld_ff[STAGES-1])
      else $error("stalled result item lost");

endmodule : thermal_pseudocolor_mapper

`default_nettype wire
